// ===== src/rfp_pkg.sv =====
// rfp_pkg: shared constants, codes and types for the radar frame parser
// used by rfp_collector, rfp_result and radar_frame_parser_top; no dependencies

package rfp_pkg;

    // frame layout
    localparam int FRAME_LENGTH = 24;
    localparam int CNT_W        = $clog2(FRAME_LENGTH);
    localparam int LAST_IDX     = FRAME_LENGTH - 1;
    localparam int HDR1_IDX     = 1;
    localparam int HDR2_IDX     = 2;
    localparam int HDR3_IDX     = 3;
    localparam int DIST_LO_IDX  = 8;
    localparam int DIST_HI_IDX  = 9;
    localparam int ENRG_LO_IDX  = 12;
    localparam int ENRG_HI_IDX  = 13;

    // header bytes
    localparam logic [7:0] START_BYTE = 8'hF4;
    localparam logic [7:0] HDR1_BYTE  = 8'hF3;
    localparam logic [7:0] HDR2_BYTE  = 8'hF2;
    localparam logic [7:0] HDR3_BYTE  = 8'hF1;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR = 2'd1;
    localparam logic [15:0] MAX_DIST_RESET   = 16'd5000;
    localparam logic [15:0] MOTION_THR_RESET = 16'd50;

    // result status codes
    localparam logic [1:0] STATUS_VALID     = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
    localparam logic [1:0] STATUS_RANGE_ERR = 2'd2;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // completed frame, handed from collector to result stage
    typedef struct packed {
        logic        valid;
        logic        header_ok;
        logic [15:0] distance;
        logic [15:0] energy;
    } frame_t;

endpackage

// ===== src/rfp_collector.sv =====
// rfp_collector: byte counter, header check and field capture for one frame
// depends on rfp_pkg

module rfp_collector (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output rfp_pkg::frame_t  frame
);

    logic [rfp_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      hdr_ok_reg, hdr_ok_next;
    logic [7:0]                dist_lo_reg, dist_lo_next;
    logic [7:0]                dist_hi_reg, dist_hi_next;
    logic [7:0]                enrg_lo_reg, enrg_lo_next;
    logic [7:0]                enrg_hi_reg, enrg_hi_next;
    logic [7:0]                enrg_hi_sel;

    always_comb begin
        count_next   = count_reg;
        hdr_ok_next  = hdr_ok_reg;
        dist_lo_next = dist_lo_reg;
        dist_hi_next = dist_hi_reg;
        enrg_lo_next = enrg_lo_reg;
        enrg_hi_next = enrg_hi_reg;
        if (accept) begin
            if (count_reg == '0) begin
                // hunting: only the start byte opens a frame
                if (rx_byte == rfp_pkg::START_BYTE) begin
                    count_next  = rfp_pkg::CNT_W'(1);
                    hdr_ok_next = 1'b1;
                end
            end else begin
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::LAST_IDX)) begin
                    count_next = '0;
                end else begin
                    count_next = count_reg + rfp_pkg::CNT_W'(1);
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::HDR1_IDX)) begin
                    hdr_ok_next = hdr_ok_reg & (rx_byte == rfp_pkg::HDR1_BYTE);
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::HDR2_IDX)) begin
                    hdr_ok_next = hdr_ok_reg & (rx_byte == rfp_pkg::HDR2_BYTE);
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::HDR3_IDX)) begin
                    hdr_ok_next = hdr_ok_reg & (rx_byte == rfp_pkg::HDR3_BYTE);
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::DIST_LO_IDX)) begin
                    dist_lo_next = rx_byte;
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::DIST_HI_IDX)) begin
                    dist_hi_next = rx_byte;
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::ENRG_LO_IDX)) begin
                    enrg_lo_next = rx_byte;
                end
                if (count_reg == rfp_pkg::CNT_W'(rfp_pkg::ENRG_HI_IDX)) begin
                    enrg_hi_next = rx_byte;
                end
            end
        end
    end

    // energy high byte is taken straight from rx_byte while it is being captured
    assign enrg_hi_sel = (count_reg == rfp_pkg::CNT_W'(rfp_pkg::ENRG_HI_IDX)) ?
                         rx_byte : enrg_hi_reg;

    always_comb begin
        frame.valid     = accept && (count_reg == rfp_pkg::CNT_W'(rfp_pkg::LAST_IDX));
        frame.header_ok = hdr_ok_reg;
        frame.distance  = {dist_hi_reg, dist_lo_reg};
        frame.energy    = {enrg_hi_sel, enrg_lo_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            hdr_ok_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            hdr_ok_reg <= hdr_ok_next;
        end
        dist_lo_reg <= dist_lo_next;
        dist_hi_reg <= dist_hi_next;
        enrg_lo_reg <= enrg_lo_next;
        enrg_hi_reg <= enrg_hi_next;
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rfp_pkg::CNT_W'(rfp_pkg::LAST_IDX))
        else $error("frame byte counter past frame length");

    a_back_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        frame.valid |=> (count_reg == '0))
        else $error("collector did not return to hunting after a frame");

endmodule

// ===== src/rfp_result.sv =====
// rfp_result: configuration registers, range and motion checks, output register
// depends on rfp_pkg

module rfp_result (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  rfp_pkg::frame_t                frame,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     frame_status,
    output logic [15:0]                    distance_cm,
    output logic [15:0]                    energy_raw,
    output logic                           moving
);

    logic [15:0] max_dist_reg, motion_thr_reg;
    logic        valid_reg, valid_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] dist_reg, dist_next;
    logic [15:0] enrg_reg, enrg_next;
    logic        moving_reg, moving_next;

    always_comb begin
        status_next = rfp_pkg::STATUS_VALID;
        dist_next   = frame.distance;
        enrg_next   = frame.energy;
        moving_next = 1'b0;
        if (!frame.header_ok) begin
            status_next = rfp_pkg::STATUS_BAD_HDR;
            dist_next   = '0;
            enrg_next   = '0;
        end else if (frame.distance > max_dist_reg) begin
            status_next = rfp_pkg::STATUS_RANGE_ERR;
        end else begin
            moving_next = frame.energy > motion_thr_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (frame.valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg   <= rfp_pkg::MAX_DIST_RESET;
            motion_thr_reg <= rfp_pkg::MOTION_THR_RESET;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == rfp_pkg::REG_MAX_DIST) begin
                max_dist_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == rfp_pkg::REG_MOTION_THR) begin
                motion_thr_reg <= cfg_wr_data;
            end
            valid_reg <= valid_next;
        end
        if (frame.valid) begin
            status_reg <= status_next;
            dist_reg   <= dist_next;
            enrg_reg   <= enrg_next;
            moving_reg <= moving_next;
        end
    end

    assign out_valid    = valid_reg;
    assign frame_status = status_reg;
    assign distance_cm  = dist_reg;
    assign energy_raw   = enrg_reg;
    assign moving       = moving_reg;

    a_moving_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && moving_reg) |-> (status_reg == rfp_pkg::STATUS_VALID))
        else $error("moving flag on a frame that is not valid");

    a_bad_hdr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg == rfp_pkg::STATUS_BAD_HDR) |->
        (dist_reg == '0 && enrg_reg == '0 && !moving_reg))
        else $error("bad header result carries data");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !frame.valid)
        else $error("new frame completed over an untaken result");

endmodule

// ===== src/radar_frame_parser_top.sv =====
// radar_frame_parser_top: top level of the radar serial frame parser
// depends on rfp_pkg, rfp_collector and rfp_result

// usage
//   s_* channel: one received serial byte per transaction in s_tdata[7:0]
//   bytes are dropped while hunting until a 0xF4 start byte opens a frame;
//   the following bytes up to the frame length are counted, header bytes
//   checked and the distance and energy bytes captured on the fly
//   m_* channel: one result transaction per completed frame, with status
//   (valid, bad header, range error), distance, energy and the moving flag
//   cfg_*: plain write port, index 0 max distance, index 1 motion threshold,
//   other indexes ignored; write only while no frame is in flight
//   result: registered, appears in the cycle after the closing byte is taken
//   throughput: one byte per cycle while s_tready is high, set by the single counter
//   and compare path between the capture registers and the result register
//   stall: s_tready drops only while a result waits and m_tready is low;
//   bytes are accepted freely while the output register is empty or drains
//   reset: synchronous active-low aresetn returns to hunting, clears the
//   pending result and loads the default register values

module radar_frame_parser_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [rfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // byte input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rfp_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] frame_status, [17:2] distance_cm, [33:18] energy_raw,
    // [34] moving, [39:35] zero
    output logic [rfp_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic            in_accept;
    rfp_pkg::frame_t frame;
    logic [1:0]      frame_status;
    logic [15:0]     distance_cm;
    logic [15:0]     energy_raw;
    logic            moving;

    // take a byte whenever the output register is free or is being emptied
    assign s_tready  = !m_tvalid || m_tready;
    assign in_accept = s_tvalid && s_tready;

    rfp_collector u_collector (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_accept),
        .rx_byte (s_tdata),
        .frame   (frame)
    );

    rfp_result u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .frame        (frame),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .frame_status (frame_status),
        .distance_cm  (distance_cm),
        .energy_raw   (energy_raw),
        .moving       (moving)
    );

    // pack result fields lowest first, pad to whole bytes
    assign m_tdata = {5'b0, moving, energy_raw, distance_cm, frame_status};

endmodule
